// ----- sv/acs_pkg.sv -----
// Shared types and constants for the axis calibrate-and-scale block.
package acs_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int AXIS_W    = 16;
   localparam int NUM_W     = 28;             // |x| * 32768 needs 27 bits, kept even
   localparam int DIV_STEPS = NUM_W / 2;      // two quotient bits per cycle
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int WIDE_W    = NUM_W + 2;      // signed quotient plus offset
   localparam int CSR_IDX_W = 1;

   localparam logic [SAMPLE_W-1:0] ADC_FULL_SCALE = 12'd4095;
   localparam logic [SAMPLE_W-1:0] CENTER_DEFAULT = 12'd2048;
   localparam logic [SAMPLE_W-1:0] DEADBAND_RESET = 12'd8;
   localparam logic [SAMPLE_W-1:0] MARGIN_RESET   = 12'd0;

   localparam logic [AXIS_W-1:0] SCALE_LOW  = 16'd32768;
   localparam logic [AXIS_W-1:0] SCALE_HIGH = 16'd32767;

   localparam logic signed [WIDE_W-1:0] AXIS_MIN = -30'sd32768;
   localparam logic signed [WIDE_W-1:0] AXIS_MAX = 30'sd32767;

   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN   = 1'b1;

   typedef enum logic [2:0] {
      KIND_SAMPLE      = 3'd0,
      KIND_START_CAL   = 3'd1,
      KIND_FINISH_CAL  = 3'd2,
      KIND_RESET_RANGE = 3'd3,
      KIND_CENTER_HELD = 3'd4,
      KIND_SET_CENTER  = 3'd5,
      KIND_SET_MIN     = 3'd6,
      KIND_SET_MAX     = 3'd7
   } kind_type;

   typedef struct packed {
      logic apply;      // beat accepted: update state from it
      logic setup;      // clamp, pick segment, form numerator
      logic div_step;   // two divider iterations
      logic finish;     // sign, offset, saturate into scaled value
      logic emit;       // load result register
   } cmd_type;

   typedef struct packed {
      logic need_rescale;
   } status_type;

endpackage

// ----- sv/acs_ctrl.sv -----
// Sequencing state machine for the axis calibrate-and-scale block.
module acs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  acs_pkg::status_type status,
   output acs_pkg::cmd_type    cmd
);
   import acs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_DIV,
      S_FINISH,
      S_EMIT
   } state_type;

   state_type        state_ff;
   logic             ready_ff;
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic accept;
   logic out_free;
   logic div_done;

   assign accept   = req_tvalid && ready_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign div_done = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      cmd          = '0;
      cmd.apply    = accept;
      cmd.setup    = (state_ff == S_SETUP);
      cmd.div_step = (state_ff == S_DIV);
      cmd.finish   = (state_ff == S_FINISH);
      cmd.emit     = (state_ff == S_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (cmd.emit)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  state_ff <= status.need_rescale ? S_SETUP : S_EMIT;
               end
            end
            S_SETUP: begin
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (div_done) state_ff <= S_FINISH;
            end
            S_FINISH: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  ready_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_tready = ready_ff;
   assign rsp_tvalid = rsp_valid_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> state_ff == S_IDLE)
      else $error("ready high outside idle");

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      accept |=> !ready_ff)
      else $error("second beat accepted while busy");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && div_done) |=> state_ff == S_FINISH)
      else $error("divider did not finish on count");

   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside emit");

endmodule

// ----- sv/acs_datapath.sv -----
// Calibration state, serial divider and result register of the axis block.
module acs_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  acs_pkg::cmd_type                   cmd,
   output acs_pkg::status_type                status,
   input  logic [2:0]                         req_kind,
   input  logic [acs_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                               csr_we,
   input  logic [acs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [acs_pkg::SAMPLE_W-1:0]       csr_data,
   output logic signed [acs_pkg::AXIS_W-1:0]  out_axis,
   output logic [acs_pkg::SAMPLE_W-1:0]       out_held,
   output logic                               out_cal,
   output logic [acs_pkg::SAMPLE_W-1:0]       out_seen_low,
   output logic [acs_pkg::SAMPLE_W-1:0]       out_seen_high
);
   import acs_pkg::*;

   // architectural state
   logic [SAMPLE_W-1:0]       held_ff, held_in;
   logic signed [AXIS_W-1:0]  scaled_ff;
   logic [SAMPLE_W-1:0]       lo_ff, lo_in;
   logic [SAMPLE_W-1:0]       hi_ff, hi_in;
   logic [SAMPLE_W-1:0]       ce_ff, ce_in;
   logic                      cal_ff, cal_in;
   logic [SAMPLE_W-1:0]       tlo_ff, tlo_in;
   logic [SAMPLE_W-1:0]       thi_ff, thi_in;
   logic                      primed_ff, primed_in;
   logic [SAMPLE_W-1:0]       deadband_ff;
   logic [SAMPLE_W-1:0]       margin_ff;

   // divider
   logic [NUM_W-1:0]          num_ff, num_in;
   logic [SAMPLE_W-1:0]       rem_ff, rem_in;
   logic [SAMPLE_W-1:0]       den_ff;
   logic                      neg_ff, zero_ff, seg_low_ff;

   // result register
   logic signed [AXIS_W-1:0]  axis_ff;
   logic [SAMPLE_W-1:0]       ohold_ff, olo_ff, ohi_ff;
   logic                      ocal_ff;

   kind_type                  kind;
   logic [SAMPLE_W-1:0]       diff;
   logic                      need;
   logic [SAMPLE_W:0]         lo_sum;
   logic signed [SAMPLE_W:0]  hi_dif;

   logic [SAMPLE_W-1:0]       r, base, top;
   logic                      seg_low;
   logic signed [SAMPLE_W:0]  x, d;
   logic [SAMPLE_W-1:0]       ax, ad;
   logic [NUM_W-1:0]          prod;

   logic signed [WIDE_W-1:0]  qs, v;
   logic signed [AXIS_W-1:0]  sat;

   function automatic logic [SAMPLE_W+NUM_W-1:0] div_iter(
      input logic [SAMPLE_W-1:0] rem,
      input logic [NUM_W-1:0]    num,
      input logic [SAMPLE_W-1:0] den
   );
      logic [SAMPLE_W:0]   t;
      logic [SAMPLE_W-1:0] rn;
      logic                q;
      t = {rem, num[NUM_W-1]};
      q = (t >= {1'b0, den});
      rn = q ? SAMPLE_W'(t - {1'b0, den}) : t[SAMPLE_W-1:0];
      return {rn, num[NUM_W-2:0], q};
   endfunction

   assign kind = kind_type'(req_kind);

   // command update, applied on the accepted beat
   always_comb begin
      held_in   = held_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      ce_in     = ce_ff;
      cal_in    = cal_ff;
      tlo_in    = tlo_ff;
      thi_in    = thi_ff;
      primed_in = primed_ff;
      need      = 1'b0;
      diff      = (req_sample > held_ff) ? req_sample - held_ff : held_ff - req_sample;
      lo_sum    = {1'b0, tlo_ff} + {1'b0, margin_ff};
      hi_dif    = $signed({1'b0, thi_ff}) - $signed({1'b0, margin_ff});
      case (kind)
         KIND_SAMPLE: begin
            if (!primed_ff) begin
               held_in   = req_sample;
               primed_in = 1'b1;
               need      = 1'b1;
            end else begin
               if (cal_ff) begin
                  if (req_sample < tlo_ff) tlo_in = req_sample;
                  if (req_sample > thi_ff) thi_in = req_sample;
               end
               if (diff > deadband_ff) begin
                  held_in = req_sample;
                  need    = 1'b1;
               end
            end
         end
         KIND_START_CAL: begin
            cal_in = 1'b1;
            thi_in = '0;
            tlo_in = ADC_FULL_SCALE;
         end
         KIND_FINISH_CAL: begin
            if (cal_ff) begin
               cal_in = 1'b0;
               if (tlo_ff < thi_ff) begin
                  hi_in = hi_dif[SAMPLE_W] ? '0 : hi_dif[SAMPLE_W-1:0];
                  lo_in = (lo_sum > {1'b0, ADC_FULL_SCALE}) ? ADC_FULL_SCALE
                                                           : lo_sum[SAMPLE_W-1:0];
                  need  = 1'b1;
               end
            end
         end
         KIND_RESET_RANGE: begin
            lo_in = '0;
            ce_in = CENTER_DEFAULT;
            hi_in = ADC_FULL_SCALE;
            need  = 1'b1;
         end
         KIND_CENTER_HELD: begin
            ce_in = held_ff;
            need  = 1'b1;
         end
         KIND_SET_CENTER: begin
            if (req_sample < lo_ff)      ce_in = lo_ff;
            else if (req_sample > hi_ff) ce_in = hi_ff;
            else                         ce_in = req_sample;
            need = 1'b1;
         end
         KIND_SET_MIN: begin
            lo_in = (req_sample > ADC_FULL_SCALE) ? ADC_FULL_SCALE : req_sample;
            need  = 1'b1;
         end
         KIND_SET_MAX: begin
            hi_in = (req_sample > ADC_FULL_SCALE) ? ADC_FULL_SCALE : req_sample;
            need  = 1'b1;
         end
         default: begin
            need = 1'b0;
         end
      endcase
   end

   assign status.need_rescale = need;

   // map setup: clamp held value, choose segment, form |x| * scale and |span|
   always_comb begin
      if (held_ff < lo_ff)      r = lo_ff;
      else if (held_ff > hi_ff) r = hi_ff;
      else                      r = held_ff;
      seg_low = (r < ce_ff);
      base    = seg_low ? lo_ff : ce_ff;
      top     = seg_low ? ce_ff : hi_ff;
      x       = $signed({1'b0, r}) - $signed({1'b0, base});
      d       = $signed({1'b0, top}) - $signed({1'b0, base});
      ax      = x[SAMPLE_W] ? SAMPLE_W'(-x) : x[SAMPLE_W-1:0];
      ad      = d[SAMPLE_W] ? SAMPLE_W'(-d) : d[SAMPLE_W-1:0];
      prod    = NUM_W'(ax) * NUM_W'(seg_low ? SCALE_LOW : SCALE_HIGH);
   end

   // two restoring iterations per cycle
   always_comb begin
      logic [SAMPLE_W+NUM_W-1:0] s1, s2;
      s1     = div_iter(rem_ff, num_ff, den_ff);
      s2     = div_iter(s1[SAMPLE_W+NUM_W-1:NUM_W], s1[NUM_W-1:0], den_ff);
      rem_in = s2[SAMPLE_W+NUM_W-1:NUM_W];
      num_in = s2[NUM_W-1:0];
   end

   // quotient truncates toward zero: sign applied to the magnitude
   always_comb begin
      qs = neg_ff ? -$signed({2'b00, num_ff}) : $signed({2'b00, num_ff});
      v  = qs + (seg_low_ff ? AXIS_MIN : '0);
      if (zero_ff)            sat = '0;
      else if (v < AXIS_MIN)  sat = AXIS_MIN[AXIS_W-1:0];
      else if (v > AXIS_MAX)  sat = AXIS_MAX[AXIS_W-1:0];
      else                    sat = v[AXIS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         scaled_ff   <= '0;
         lo_ff       <= '0;
         hi_ff       <= ADC_FULL_SCALE;
         ce_ff       <= CENTER_DEFAULT;
         cal_ff      <= 1'b0;
         tlo_ff      <= ADC_FULL_SCALE;
         thi_ff      <= '0;
         primed_ff   <= 1'b0;
         deadband_ff <= DEADBAND_RESET;
         margin_ff   <= MARGIN_RESET;
      end else begin
         if (cmd.apply) begin
            held_ff   <= held_in;
            lo_ff     <= lo_in;
            hi_ff     <= hi_in;
            ce_ff     <= ce_in;
            cal_ff    <= cal_in;
            tlo_ff    <= tlo_in;
            thi_ff    <= thi_in;
            primed_ff <= primed_in;
         end
         if (cmd.finish) scaled_ff <= sat;
         if (csr_we) begin
            case (csr_index)
               CSR_DEADBAND: deadband_ff <= csr_data;
               CSR_MARGIN:   margin_ff   <= csr_data;
               default:      deadband_ff <= deadband_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         num_ff     <= prod;
         rem_ff     <= '0;
         den_ff     <= ad;
         neg_ff     <= x[SAMPLE_W] ^ d[SAMPLE_W];
         zero_ff    <= (d == '0);
         seg_low_ff <= seg_low;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
      if (cmd.emit) begin
         axis_ff  <= scaled_ff;
         ohold_ff <= held_ff;
         ocal_ff  <= cal_ff;
         olo_ff   <= tlo_ff;
         ohi_ff   <= thi_ff;
      end
   end

   assign out_axis      = axis_ff;
   assign out_held      = ohold_ff;
   assign out_cal       = ocal_ff;
   assign out_seen_low  = olo_ff;
   assign out_seen_high = ohi_ff;

   a_held_on_apply: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.apply) |-> $stable(held_ff))
      else $error("held value changed without a beat");

   a_scaled_on_finish: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.finish) |-> $stable(scaled_ff))
      else $error("axis value changed outside finish");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.setup, cmd.div_step, cmd.finish, cmd.emit}))
      else $error("overlapping datapath commands");

endmodule

// ----- sv/axis_calibrate_and_scale.sv -----
// Top level: ADC axis deadband, calibration and center mapping.
//
// Channels: req_ carries one command beat (kind in tuser, raw value in tdata);
// rsp_ returns exactly one result beat per command with the state after it.
// csr_ writes deadband (index 0) or cal_margin (index 1); csr_ready is always
// high, writes are expected only while the block is idle.
//
// A command that leaves the axis value alone goes from idle straight to the
// emit state. A command that remaps (first sample, sample past the deadband,
// range or center change) runs the setup state, the divider steps at two
// quotient bits each and the finish state before the emit state.
// One command is in flight at a time: the next is not taken until the emit
// state has loaded the result, and loading waits while the result side stalls.
// The result register frees req_tready as soon as the result is loaded, so
// the next command is taken while the previous result waits.
// If the receiver stalls, the finished result holds in rsp_tdata and a
// second finished result waits internally until the first is taken.
// Reset (synchronous): range 0..4095, center 2048, deadband 8, margin 0,
// held value 0, not calibrating; the first sample then loads directly.
module axis_calibrate_and_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,  // [11:0] sample
   input  logic [2:0]                    req_tuser,  // [2:0] kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [15:0] axis_value, [27:16] held_sample, [28] cal_busy,
   // [40:29] seen_low, [52:41] seen_high
   output logic [55:0]                   rsp_tdata,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [acs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [acs_pkg::SAMPLE_W-1:0]  csr_data
);
   import acs_pkg::*;

   cmd_type                  cmd;
   status_type               status;
   logic signed [AXIS_W-1:0] out_axis;
   logic [SAMPLE_W-1:0]      out_held, out_seen_low, out_seen_high;
   logic                     out_cal;

   assign csr_ready = 1'b1;

   acs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   acs_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_kind      (req_tuser),
      .req_sample    (req_tdata[SAMPLE_W-1:0]),
      .csr_we        (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .out_axis      (out_axis),
      .out_held      (out_held),
      .out_cal       (out_cal),
      .out_seen_low  (out_seen_low),
      .out_seen_high (out_seen_high)
   );

   assign rsp_tdata = {3'b000, out_seen_high, out_seen_low, out_cal, out_held, out_axis};

endmodule
